/* src/bss_pkg.sv */
package bss_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned POS_OUT_W = 32;

  // Item kinds; the remaining code is ignored.
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TEXT   = 2'd2;

  // Per-cycle control broadcast to every cell of the row.
  typedef struct packed {
    logic              text;    // text byte accepted: advance the partial matches
    logic              clear;   // drop all partial matches
    logic              append;  // pattern byte accepted
    logic [BYTE_W-1:0] data;
  } bss_ctl_t;

  // One result transaction.
  typedef struct packed {
    logic                 found;
    logic [POS_OUT_W-1:0] position;
  } bss_res_t;

endpackage

/* src/bss_if.sv */
interface bss_in_if;
  import bss_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output kind, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, input last_byte, output ready);
endinterface

interface bss_out_if;
  import bss_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [POS_OUT_W-1:0] position;

  modport source (output valid, output found, output position, input ready);
  modport sink   (input valid, input found, input position, output ready);
endinterface

/* src/bss_cell.sv */
module bss_cell #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned LEN_W    = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bss_pkg::bss_ctl_t ctl_i,
  input  logic [LEN_W-1:0] len_i,
  input  logic             prev_pm_i,
  output logic             pm_o,
  output logic             hit_o
);
  import bss_pkg::*;

  logic [BYTE_W-1:0] pat_q;
  logic              pm_q, pm_d;
  logic              pm_new;
  logic              is_last;
  logic              wr_en;

  assign wr_en   = ctl_i.append && (len_i == LEN_W'(CELL_IDX));
  assign is_last = (len_i == LEN_W'(CELL_IDX + 1));
  assign pm_new  = prev_pm_i && (pat_q == ctl_i.data);

  always_comb begin
    priority if (ctl_i.clear) begin
      pm_d = 1'b0;
    end else if (ctl_i.text) begin
      pm_d = pm_new;
    end else begin
      pm_d = pm_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pm_q <= 1'b0;
    end else begin
      pm_q <= pm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pat_q <= ctl_i.data;
    end
  end

  assign pm_o  = pm_q;
  // Full match ends at this byte when this cell holds the final pattern byte.
  assign hit_o = ctl_i.text && is_last && pm_new;

endmodule

/* src/bss_cell_row.sv */
module bss_cell_row #(
  parameter int unsigned PATTERN_MAX = 64,
  parameter int unsigned LEN_W       = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bss_pkg::bss_ctl_t ctl_i,
  input  logic [LEN_W-1:0]  len_i,
  output logic              hit_o
);
  import bss_pkg::*;

  logic [PATTERN_MAX-1:0] pm;
  logic [PATTERN_MAX-1:0] hit;

  for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
    logic prev_pm;
    if (g == 0) begin : g_head
      assign prev_pm = 1'b1;
    end else begin : g_link
      assign prev_pm = pm[g-1];
    end

    bss_cell #(
      .CELL_IDX (g),
      .LEN_W    (LEN_W)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl_i),
      .len_i     (len_i),
      .prev_pm_i (prev_pm),
      .pm_o      (pm[g]),
      .hit_o     (hit[g])
    );
  end

  assign hit_o = |hit;

endmodule

/* src/bss_out_buf.sv */
module bss_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bss_pkg::bss_res_t  data_i,
  output logic               ready_o,
  bss_out_if.source          out_o
);
  import bss_pkg::*;

  logic     out_vld_q, out_vld_d;
  logic     skd_vld_q, skd_vld_d;
  bss_res_t out_q, out_d;
  bss_res_t skd_q, skd_d;
  logic     pop;

  assign pop     = out_vld_q && out_o.ready;
  assign ready_o = !skd_vld_q;

  always_comb begin
    out_vld_d = out_vld_q;
    skd_vld_d = skd_vld_q;
    out_d     = out_q;
    skd_d     = skd_q;
    if (pop) begin
      if (skd_vld_q) begin
        out_d     = skd_q;
        skd_vld_d = 1'b0;
      end else begin
        out_vld_d = push_i;
        out_d     = data_i;
      end
    end else if (push_i) begin
      if (out_vld_q) begin
        skd_vld_d = 1'b1;
        skd_d     = data_i;
      end else begin
        out_vld_d = 1'b1;
        out_d     = data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      skd_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      skd_vld_q <= skd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    skd_q <= skd_d;
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.found    = out_q.found;
  assign out_o.position = out_q.position;

endmodule

/* src/binary_substring_search.sv */
// Exact byte-pattern search with first-match offset. Send a clear transaction, then one
// append transaction per pattern byte (up to PATTERN_MAX; extra bytes are dropped), then
// stream text bytes; the text byte flagged last_byte yields one result transaction with
// found and the offset of the first complete occurrence (0 when not found, and an empty
// pattern always matches at 0). Clear and append also reset the text in progress. The
// block takes one transaction every clock cycle while ready is high, results included:
// a row of PATTERN_MAX cells, each holding one pattern byte and one partial-match bit,
// advances in parallel on every text byte, and the result of the last byte is registered
// in the output buffer. A two-entry output buffer takes one more result while the output
// stalls; ready drops only while both entries hold results, and rises again the cycle
// after the oldest result is taken. The text offset saturates at 2^POSITION_BITS - 1.
module binary_substring_search #(
  parameter int unsigned PATTERN_MAX   = 64,
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bss_in_if.sink    in_i,
  bss_out_if.source out_o
);
  import bss_pkg::*;

  localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int unsigned CMP_W = (POSITION_BITS > LEN_W) ? POSITION_BITS : LEN_W;
  localparam int unsigned EXT_W = POSITION_BITS + POS_OUT_W;

  logic [LEN_W-1:0]         len_q, len_d;
  logic [POSITION_BITS-1:0] toff_q, toff_d;
  logic                     seen_q, seen_d;
  logic [POSITION_BITS-1:0] moff_q, moff_d;

  logic                     acc;
  logic                     is_text, is_append, is_clear, text_last;
  bss_ctl_t                 ctl;
  logic                     row_hit, hit_now;
  logic                     seen_now;
  logic [CMP_W-1:0]         toff_ext, len_m1, diff;
  logic [POSITION_BITS-1:0] cand_off, off_now;
  logic [EXT_W-1:0]         off_wide;
  bss_res_t                 res;
  logic                     buf_ready;

  // Accept whenever the output buffer has room for a result.
  assign in_i.ready = buf_ready;
  assign acc        = in_i.valid && in_i.ready;

  assign is_text   = acc && (in_i.kind == KIND_TEXT);
  assign is_append = acc && (in_i.kind == KIND_APPEND);
  assign is_clear  = acc && (in_i.kind == KIND_CLEAR);
  assign text_last = is_text && in_i.last_byte;

  // Broadcast to the cell row: a pattern change or the end of a text drops all partial
  // matches, after the final byte has been checked.
  assign ctl.text   = is_text;
  assign ctl.clear  = is_clear || is_append || text_last;
  assign ctl.append = is_append;
  assign ctl.data   = in_i.data_byte;

  bss_cell_row #(
    .PATTERN_MAX (PATTERN_MAX),
    .LEN_W       (LEN_W)
  ) u_row (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .len_i  (len_q),
    .hit_o  (row_hit)
  );

  // Pattern length: clear empties it, append grows it until the row is full.
  always_comb begin
    priority if (is_clear) begin
      len_d = '0;
    end else if (is_append && (len_q < LEN_W'(PATTERN_MAX))) begin
      len_d = len_q + 1'b1;
    end else begin
      len_d = len_q;
    end
  end

  // An empty pattern matches at every text byte; otherwise the cell holding the final
  // pattern byte reports a complete match ending at this byte.
  assign hit_now = is_text && ((len_q == '0) || row_hit);

  // Start of the match = current offset - (length - 1), floored at zero once the offset
  // has saturated.
  assign toff_ext = CMP_W'(toff_q);
  assign len_m1   = CMP_W'(len_q) - 1'b1;
  assign diff     = toff_ext - len_m1;

  always_comb begin
    priority if (len_q == '0) begin
      cand_off = '0;
    end else if (toff_ext >= len_m1) begin
      cand_off = POSITION_BITS'(diff);
    end else begin
      cand_off = '0;
    end
  end

  // Keep the first match only.
  assign seen_now = seen_q || hit_now;
  assign off_now  = seen_q ? moff_q : (hit_now ? cand_off : '0);

  always_comb begin
    toff_d = toff_q;
    seen_d = seen_q;
    moff_d = moff_q;
    priority if (ctl.clear) begin
      toff_d = '0;
      seen_d = 1'b0;
      moff_d = '0;
    end else if (is_text) begin
      seen_d = seen_now;
      moff_d = off_now;
      if (toff_q != '1) begin
        toff_d = toff_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      toff_q <= '0;
      seen_q <= 1'b0;
      moff_q <= '0;
    end else begin
      len_q  <= len_d;
      toff_q <= toff_d;
      seen_q <= seen_d;
      moff_q <= moff_d;
    end
  end

  // Report the low bits of the offset, zero-extended for narrow counters.
  assign off_wide     = EXT_W'(off_now);
  assign res.found    = seen_now;
  assign res.position = seen_now ? off_wide[POS_OUT_W-1:0] : '0;

  bss_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (text_last),
    .data_i  (res),
    .ready_o (buf_ready),
    .out_o   (out_o)
  );

`ifndef SYNTHESIS
  // Input stalls only while both buffer entries hold results.
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid)
    else $error("input stalled with empty output register");

  // The last text byte always leaves a result ready in the next cycle.
  a_result_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    text_last |=> out_o.valid)
    else $error("result transaction missing after last text byte");

  // Pattern length never passes the row size.
  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(PATTERN_MAX))
    else $error("pattern length beyond row size");

  // A recorded match never starts past the current text offset.
  a_off_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q |-> (moff_q <= toff_q))
    else $error("match offset beyond text offset");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

// Pattern search bench: clear/append/text transactions go in, one found/position result
// comes out per text. A scoreboard model in this file tracks pattern and text state
// and queues the result each closing text byte should produce.
module tb_top;
  import bss_pkg::*;

  // The package leaves the fourth kind code unnamed; the block must ignore it.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int unsigned PAT_MAX     = 64;
  localparam int unsigned POS_BITS    = 32;
  localparam int unsigned ITEM_TARGET = 550;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 150;

  logic clk = 1'b0;
  logic rst_n;

  bss_in_if  in_if ();
  bss_out_if out_if ();

  binary_substring_search #(
    .PATTERN_MAX  (PAT_MAX),
    .POSITION_BITS(POS_BITS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  // 4 ns period, high then low.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Scoreboard model state: pattern bytes, shift-and partial match bits, text progress.
  logic [7:0]          pat_bytes [PAT_MAX];
  int unsigned         pat_len;
  logic [PAT_MAX-1:0]  partial_bits;
  logic [POS_BITS-1:0] text_pos;
  logic                hit_seen;
  logic [POS_BITS-1:0] hit_pos;

  bss_res_t    expected_hits [$];
  int unsigned err_count;
  int unsigned items_sent;

  // Flow control knobs shared by the tests.
  bit          no_gap;      // sender offers every cycle
  bit          no_stall;    // receiver always ready
  int unsigned hold_left;   // receiver hold-off cycles still to go
  int unsigned quiet_cycles;

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t mismatch %s: expected %0h got %0h", $realtime, what, want, got);
    err_count++;
  endtask

  function automatic void clear_text_state();
    partial_bits = '0;
    text_pos     = '0;
    hit_seen     = 1'b0;
    hit_pos      = '0;
  endfunction

  // Advance the model by one accepted transaction; queue a result on a closing text byte.
  function automatic void predict_search(input logic [KIND_W-1:0] kind, input logic [7:0] b,
                                         input logic last);
    logic [PAT_MAX-1:0] nxt;
    bss_res_t           res;
    case (kind)
      KIND_CLEAR: begin
        pat_len = 0;
        clear_text_state();
      end
      KIND_APPEND: begin
        // A full pattern drops further bytes but still restarts the text.
        if (pat_len < PAT_MAX) begin
          pat_bytes[pat_len] = b;
          pat_len++;
        end
        clear_text_state();
      end
      KIND_TEXT: begin
        if (pat_len == 0) begin
          // Empty pattern matches at the start of every text.
          if (!hit_seen) begin
            hit_seen = 1'b1;
            hit_pos  = '0;
          end
        end else begin
          nxt = partial_bits;
          for (int j = 1; j < pat_len; j++)
            nxt[j] = partial_bits[j-1] && (pat_bytes[j] == b);
          nxt[0] = (pat_bytes[0] == b);
          partial_bits = nxt;
          if (partial_bits[pat_len-1] && !hit_seen) begin
            hit_seen = 1'b1;
            hit_pos  = (text_pos >= POS_BITS'(pat_len - 1)) ?
                       text_pos - POS_BITS'(pat_len - 1) : '0;
          end
        end
        // Saturate the offset at all ones.
        if (text_pos != '1) text_pos++;
        if (last) begin
          res.found    = hit_seen;
          res.position = hit_seen ? POS_OUT_W'(hit_pos) : '0;
          expected_hits.push_back(res);
          clear_text_state();
        end
      end
      default: ;
    endcase
  endfunction

  // Offer one transaction, with random idle cycles ahead of it, and hold it until taken.
  // Inputs change only at the falling edge; ready is sampled at the rising edge.
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [7:0] b,
                           input logic last);
    bit taken;
    while (!no_gap && $urandom_range(99) < 36) begin
      @(negedge clk);
      in_if.valid = 1'b0;
    end
    @(negedge clk);
    in_if.valid     = 1'b1;
    in_if.kind      = kind;
    in_if.data_byte = b;
    in_if.last_byte = last;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = in_if.ready;
    end
    predict_search(kind, b, last);
    items_sent++;
  endtask

  // Drop valid and hold until every queued result has been seen.
  task automatic wait_drain();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
  endtask

  task automatic send_text(input logic [7:0] txt [$]);
    foreach (txt[i]) send_item(KIND_TEXT, txt[i], i == txt.size() - 1);
  endtask

  // Mostly one of two symbols per round so matches and near misses are frequent.
  function automatic logic [7:0] pick_symbol(input logic [7:0] sym_a, input logic [7:0] sym_b);
    if ($urandom_range(9) == 0) return 8'($urandom);
    return $urandom_range(1) ? sym_a : sym_b;
  endfunction

  // One well-formed search: clear, load a pattern, then a few texts, some of them
  // carrying the pattern. Sprinkle unused kinds and mid-text appends as noise.
  task automatic random_search_round();
    logic [7:0] sym_a, sym_b;
    logic [7:0] pat [$];
    logic [7:0] txt [$];
    int         plen, tlen, at, r;
    sym_a = 8'($urandom);
    sym_b = 8'($urandom);
    r = $urandom_range(99);
    plen = (r < 5) ? 0 : (r < 88) ? $urandom_range(4, 1) :
           (r < 97) ? $urandom_range(10, 5) : $urandom_range(66, 60);
    for (int i = 0; i < plen; i++) pat.push_back(pick_symbol(sym_a, sym_b));
    send_item(KIND_CLEAR, 8'($urandom), 1'($urandom));
    foreach (pat[i]) send_item(KIND_APPEND, pat[i], $urandom_range(9) == 0);
    repeat ($urandom_range(3, 1)) begin
      txt.delete();
      tlen = $urandom_range(plen + 8, 1);
      for (int i = 0; i < tlen; i++) txt.push_back(pick_symbol(sym_a, sym_b));
      if (plen > 0 && plen <= tlen && $urandom_range(1)) begin
        at = $urandom_range(tlen - plen);
        for (int j = 0; j < plen; j++) txt[at+j] = pat[j];
      end
      foreach (txt[i]) begin
        if ($urandom_range(99) < 4)
          send_item(KIND_UNUSED, 8'($urandom), 1'($urandom));
        else if ($urandom_range(99) < 2)
          send_item(KIND_APPEND, pick_symbol(sym_a, sym_b), 1'($urandom));
        send_item(KIND_TEXT, txt[i], i == txt.size() - 1);
      end
    end
  endtask

  // Out of reset the pattern is empty: every text matches at offset 0.
  task automatic test_empty_pattern();
    send_item(KIND_TEXT, 8'h00, 1'b1);
    send_item(KIND_TEXT, 8'hFF, 1'b0);
    send_item(KIND_TEXT, 8'h00, 1'b1);
    send_item(KIND_CLEAR, 8'h00, 1'b0);
    send_item(KIND_TEXT, 8'h5A, 1'b1);
    wait_drain();
  endtask

  // Extreme bytes, match in the middle and at the start, a partial match cut off by the
  // end of text, an ignored kind, last flags on pattern items, and a pattern change
  // in the middle of a text.
  task automatic test_directed();
    send_item(KIND_CLEAR, 8'hFF, 1'b1);
    send_item(KIND_APPEND, 8'h00, 1'b0);
    send_item(KIND_APPEND, 8'hFF, 1'b1);
    send_text({8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00});
    send_text({8'h00});
    send_text({8'h00, 8'hFF});
    send_item(KIND_UNUSED, 8'hAA, 1'b1);
    send_item(KIND_TEXT, 8'h00, 1'b0);
    send_item(KIND_APPEND, 8'hFF, 1'b0);
    send_text({8'hFF, 8'hFF});
    wait_drain();
  endtask

  // Fill the pattern store, push two bytes past it, then search for the stored part.
  task automatic test_full_pattern();
    logic [7:0] pat [$];
    logic [7:0] txt [$];
    for (int i = 0; i < PAT_MAX + 2; i++) pat.push_back(8'($urandom));
    send_item(KIND_CLEAR, 8'h00, 1'b0);
    foreach (pat[i]) send_item(KIND_APPEND, pat[i], 1'b0);
    txt.push_back(8'($urandom));
    txt.push_back(8'($urandom));
    for (int i = 0; i < PAT_MAX; i++) txt.push_back(pat[i]);
    send_text(txt);
    wait_drain();
  endtask

  // Hold the receiver off while one-byte texts keep coming, so the output buffer
  // fills and input ready drops.
  task automatic test_output_backpressure();
    logic [7:0] sym;
    sym = 8'($urandom);
    send_item(KIND_CLEAR, 8'h00, 1'b0);
    send_item(KIND_APPEND, sym, 1'b0);
    no_gap    = 1'b1;
    hold_left = HOLD_CYCLES;
    repeat (30) send_item(KIND_TEXT, $urandom_range(1) ? sym : 8'($urandom), 1'b1);
    no_gap = 1'b0;
    wait_drain();
  endtask

  // Run back to back with no gaps and no stalls for a stretch.
  task automatic test_full_rate();
    int unsigned stop_at;
    stop_at  = items_sent + 120;
    no_gap   = 1'b1;
    no_stall = 1'b1;
    while (items_sent < stop_at) random_search_round();
    wait_drain();
    no_gap   = 1'b0;
    no_stall = 1'b0;
  endtask

  // Random searches up to the item target; now and then pause until everything
  // has drained.
  task automatic test_random_search();
    while (items_sent < ITEM_TARGET) begin
      random_search_round();
      if ($urandom_range(9) == 0) wait_drain();
    end
  endtask

  // Receiver: hold-off first, then always-ready or random stalls.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_if.ready = 1'b0;
      hold_left--;
    end else if (no_stall) begin
      out_if.ready = 1'b1;
    end else begin
      out_if.ready = ($urandom_range(99) >= 36);
    end
  end

  // Compare every result transaction with the oldest queued expectation.
  always @(posedge clk) begin
    bss_res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_hits.size() == 0) begin
        report_mismatch("unexpected result", 32'd0, {31'd0, out_if.found});
      end else begin
        want = expected_hits.pop_front();
        if (out_if.found !== want.found)
          report_mismatch("found", 32'(want.found), 32'(out_if.found));
        if (out_if.position !== want.position)
          report_mismatch("position", want.position, out_if.position);
      end
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t watchdog: no progress, %0d results outstanding", $realtime,
                 expected_hits.size());
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.kind      = KIND_CLEAR;
    in_if.data_byte = 8'h00;
    in_if.last_byte = 1'b0;
    out_if.ready    = 1'b0;
    no_gap          = 1'b0;
    no_stall        = 1'b0;
    hold_left       = 0;
    quiet_cycles    = 0;
    err_count       = 0;
    items_sent      = 0;
    pat_len         = 0;
    clear_text_state();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_pattern();
    test_directed();
    test_full_pattern();
    test_output_backpressure();
    test_full_rate();
    test_random_search();

    // Drain, then give the block a few cycles to show any stray result.
    wait_drain();
    repeat (8) @(posedge clk);
    if (err_count == 0 && expected_hits.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
